[rtl/core/swhc_pkg.sv]
// Shared constants and the ring entry type for the sliding window hit counter.
// Used by the top level and the output register; no dependencies.
package swhc_pkg;

	localparam int BUCKETS          = 512;
	localparam int PTR_W            = $clog2(BUCKETS);
	localparam int OCC_W            = $clog2(BUCKETS + 1);
	localparam int TIME_W           = 31;
	localparam int HITS_W           = 32;
	localparam int WIN_W            = 10;
	localparam int ENTRY_W          = TIME_W + HITS_W;
	localparam int WINDOW_LEN_RESET = 300;

	typedef logic [HITS_W-1:0] hits_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		time_t btime;
		hits_t bhits;
	} entry_t;

endpackage

[rtl/core/swhc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependencies.
module swhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/swhc_out_reg.sv]
// Output register for result items: holds one result while the sink stalls.
// Depends on swhc_pkg for the result width.
module swhc_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  swhc_pkg::hits_t load_data,
	output logic          load_ok,
	output logic          out_valid,
	input  logic          out_stall,
	output swhc_pkg::hits_t hits_in_window
);

	logic            valid_q;
	swhc_pkg::hits_t data_q;

	// Take a new result when empty or when the held one leaves this cycle.
	assign load_ok        = !valid_q || !out_stall;
	assign out_valid      = valid_q;
	assign hits_in_window = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			data_q <= load_data;
		end
	end

endmodule

[rtl/core/sliding_window_hit_counter_core.sv]
// Top level of the sliding window hit counter: sequencer, ring pointers and total.
// Depends on swhc_pkg, swhc_ram and swhc_out_reg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | cmd (1b), timestamp (31b)
//  result   | out_valid / out_stall| hits_in_window (32b)
//  config   | cfg_wr_en            | window_len (10b), written at once
//
// An item passes through an accept step, a check step for each bucket it retires, one
// more check step to see the first bucket that stays (not taken when the ring is empty on
// arrival or when the item retires every bucket it finds), and an update step. The expiry
// walk is set by the single read port of the ring memory, one bucket a cycle.
// Reset clears pointers, fill count, total and the window length (to 300); the ring
// memory is not cleared, since only occupied entries are ever read.
// A stalled result holds in the output register; the next item is still accepted
// and waits in its update cycle until the output register frees up.
module sliding_window_hit_counter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [swhc_pkg::TIME_W-1:0]   timestamp,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [swhc_pkg::HITS_W-1:0]   hits_in_window,
	input  logic                          cfg_wr_en,
	input  logic [swhc_pkg::WIN_W-1:0]    window_len
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE
	} state_t;

	// Advance a ring index, wrapping at the last bucket.
	function automatic logic [swhc_pkg::PTR_W-1:0] ring_next(
		input logic [swhc_pkg::PTR_W-1:0] p
	);
		return (p == swhc_pkg::PTR_W'(swhc_pkg::BUCKETS - 1)) ?
			'0 : p + 1'b1;
	endfunction

	// Increment, holding at all ones.
	function automatic swhc_pkg::hits_t sat_inc(input swhc_pkg::hits_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	state_t                        state_q;
	logic                          cmd_q;
	swhc_pkg::time_t               ts_q;
	logic [swhc_pkg::WIN_W-1:0]    win_q;
	logic [swhc_pkg::PTR_W-1:0]    oldest_ptr_q;
	logic [swhc_pkg::PTR_W-1:0]    newest_ptr_q;
	logic [swhc_pkg::OCC_W-1:0]    occ_q;
	swhc_pkg::hits_t               total_q;
	// Register copy of the newest bucket, so a hit needs no memory read.
	swhc_pkg::time_t               newest_time_q;
	swhc_pkg::hits_t               newest_hits_q;

	logic                          accept;
	logic                          rd_en;
	logic [swhc_pkg::PTR_W-1:0]    rd_addr;
	swhc_pkg::entry_t              rd_entry;
	logic                          wr_en;
	logic [swhc_pkg::PTR_W-1:0]    wr_addr;
	swhc_pkg::entry_t              wr_entry;

	logic [swhc_pkg::TIME_W:0]     due;
	logic                          expire;
	logic [swhc_pkg::PTR_W-1:0]    oldest_next;
	logic [swhc_pkg::OCC_W-1:0]    occ_dec;
	swhc_pkg::hits_t               total_sub;

	logic                          same;
	logic                          full;
	logic                          fold;
	logic [swhc_pkg::PTR_W-1:0]    new_slot;
	swhc_pkg::hits_t               hits_inc;
	swhc_pkg::hits_t               total_inc;
	swhc_pkg::hits_t               result;
	logic                          load_ok;
	logic                          commit;

	// Accept only between items; the output register decouples the result side.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// Expiry test on the oldest bucket, read out of the ring last cycle.
	assign due         = {1'b0, rd_entry.btime} +
		{{(swhc_pkg::TIME_W + 1 - swhc_pkg::WIN_W){1'b0}}, win_q};
	assign expire      = (due <= {1'b0, ts_q});
	assign oldest_next = ring_next(oldest_ptr_q);
	assign occ_dec     = occ_q - 1'b1;
	assign total_sub   = (total_q >= rd_entry.bhits) ? total_q - rd_entry.bhits : '0;

	// Fetch the oldest bucket on accept, then the next one after each retire.
	assign rd_en   = (accept && (occ_q != '0)) ||
		((state_q == ST_CHECK) && expire && (occ_dec != '0));
	assign rd_addr = (state_q == ST_IDLE) ? oldest_ptr_q : oldest_next;

	// Hit placement: fold into the newest bucket on a time match or a full ring.
	assign same      = (occ_q != '0) && (newest_time_q == ts_q);
	assign full      = (occ_q == swhc_pkg::OCC_W'(swhc_pkg::BUCKETS));
	assign fold      = same || full;
	assign new_slot  = (occ_q == '0) ? oldest_ptr_q : ring_next(newest_ptr_q);
	assign hits_inc  = sat_inc(newest_hits_q);
	assign total_inc = sat_inc(total_q);
	assign result    = cmd_q ? total_inc : total_q;

	assign commit         = (state_q == ST_UPDATE) && load_ok;
	assign wr_en          = commit && cmd_q;
	assign wr_addr        = fold ? newest_ptr_q : new_slot;
	assign wr_entry.btime = fold ? newest_time_q : ts_q;
	assign wr_entry.bhits = fold ? hits_inc : swhc_pkg::HITS_W'(1);

	swhc_ram #(
		.WIDTH (swhc_pkg::ENTRY_W),
		.DEPTH (swhc_pkg::BUCKETS)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	swhc_out_reg u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (commit),
		.load_data      (result),
		.load_ok        (load_ok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hits_in_window (hits_in_window)
	);

	// Item payload: capture on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			ts_q  <= timestamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swhc_pkg::WIN_W'(swhc_pkg::WINDOW_LEN_RESET);
		end else if (cfg_wr_en) begin
			win_q <= window_len;
		end
	end

	// Sequencer with ring pointers, fill count and running total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			oldest_ptr_q <= '0;
			newest_ptr_q <= '0;
			occ_q        <= '0;
			total_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (occ_q != '0) ? ST_CHECK : ST_UPDATE;
					end
				end
				ST_CHECK: begin
					if (expire) begin
						// Retire the oldest bucket; keep walking while any remain.
						total_q      <= total_sub;
						oldest_ptr_q <= oldest_next;
						occ_q        <= occ_dec;
						if (occ_dec == '0) begin
							state_q <= ST_UPDATE;
						end
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// Hold here until the output register can take the result.
					if (load_ok) begin
						state_q <= ST_IDLE;
						if (cmd_q) begin
							total_q <= total_inc;
							if (!fold) begin
								newest_ptr_q <= new_slot;
								occ_q        <= occ_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Newest bucket mirror: payload, follows every ring write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			newest_time_q <= wr_entry.btime;
			newest_hits_q <= wr_entry.bhits;
		end
	end

endmodule
